FILE: rtl/core/lpcr_pkg.sv
package lpcr_pkg;

   // Result width and mapping constants
   localparam int PCT_W = 7;
   localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;
   localparam logic [PCT_W-1:0] MOVE_LIMIT = 7'd2;
   localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
   localparam int DEADBAND_DIV = 20;

   // Calibration register indexes
   localparam logic REG_MIN_RAW = 1'b0;
   localparam logic REG_MAX_RAW = 1'b1;

   // Extra bits a value grows by when scaled by FULL_SCALE
   localparam int MUL_EXTRA = 7;

   // Divider iteration counter width (covers up to 31 quotient bits)
   localparam int CNT_W = 5;

   // Command to the serial divider
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] iters;
   } div_cmd_type;

   // Status back from the serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: rtl/core/lpcr_div.sv
module lpcr_div import lpcr_pkg::*; #(
   parameter int DVD_W = 17,
   parameter int DVS_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  div_cmd_type      cmd,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_stat_type     stat,
   output logic [DVD_W-1:0] quotient
);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
         cnt_in  = cmd.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

FILE: rtl/core/lpcr_track.sv
module lpcr_track import lpcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [PCT_W-1:0] pos,
   input  logic             commit,
   output logic             changed
);

   logic             has_ff, has_in;
   logic [PCT_W-1:0] last_ff, last_in;
   logic [PCT_W-1:0] delta;
   logic             extreme;

   // Report rule: first sample, a move beyond the limit, or landing on an end stop
   assign delta   = (pos > last_ff) ? (pos - last_ff) : (last_ff - pos);
   assign extreme = ((pos == PCT_ZERO) || (pos == FULL_SCALE)) && (pos != last_ff);
   assign changed = !has_ff || (delta > MOVE_LIMIT) || extreme;

   always_comb begin
      has_in  = has_ff;
      last_in = last_ff;
      if (commit && changed) begin
         has_in  = 1'b1;
         last_in = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff  <= 1'b0;
         last_ff <= '0;
      end else begin
         has_ff  <= has_in;
         last_ff <= last_in;
      end
   end

endmodule

FILE: rtl/core/lever_percent_change_reporter.sv
// Lever position reporter: maps a raw converter sample onto 0..100 percent
// between two calibration points, with a 1/20 deadband trimmed at each end,
// and flags whether the position should be reported.
//
// Channels: req_* carries one raw sample per beat, rsp_* one result per beat
// (position and change flag). A beat moves when valid is high and stall low.
// csr_write/csr_index/csr_wdata set min_raw (index 0) and max_raw (index 1);
// write them only while the block is idle.
//
// Sequencing: one sample at a time. Both the deadband and the mapping division
// run through one shared restoring divider, one quotient bit per cycle:
// SAMPLE_BITS quotient bits for the deadband, SAMPLE_BITS+7 for the mapping. A
// sample passes through BAND, EDGE, MAP, MUL, QUOT and REPORT before its result
// is registered; MUL and QUOT are skipped when the trimmed span is zero. req_stall
// is high from acceptance until the result moves into the output register.
//
// Reset: calibration returns to min 0 / max all ones (capped at 1023), nothing is reported
// yet, and the next result always carries changed = 1. If rsp_stall holds, the
// result waits in the output register; one further sample can be processed and
// then waits until the output register frees up.
module lever_percent_change_reporter import lpcr_pkg::*; #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PCT_W-1:0]       rsp_position_percent,
   output logic                   rsp_changed,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [SAMPLE_BITS-1:0] csr_wdata
);

   localparam int S     = SAMPLE_BITS;
   localparam int W     = S + 2;
   localparam int DVD_W = S + MUL_EXTRA;
   localparam int MAX_RESET = (S >= 10) ? 1023 : ((1 << S) - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BAND   = 3'd1;
   localparam logic [2:0] ST_EDGE   = 3'd2;
   localparam logic [2:0] ST_MAP    = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_QUOT   = 3'd5;
   localparam logic [2:0] ST_REPORT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [S-1:0]     min_ff, min_in;
   logic [S-1:0]     max_ff, max_in;
   logic [S-1:0]     x_ff, x_in;
   logic             neg_ff, neg_in;
   logic [W-1:0]     band_ff, band_in;
   logic [W-1:0]     edge_ff, edge_in;
   logic [W-1:0]     span_ff, span_in;
   logic [W-1:0]     diff_ff, diff_in;
   logic [PCT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_chg_ff, rsp_chg_in;

   logic             req_take;
   logic             ld;
   logic [W-1:0]     dlt;
   logic [W-1:0]     dlt_abs;
   logic [W-1:0]     band_mag;
   logic [W-1:0]     diff_abs;
   logic [W-1:0]     span_abs;
   logic [DVD_W-1:0] num;
   logic [DVD_W-1:0] quotient;
   logic [DVD_W-1:0] div_dvd;
   logic [S-1:0]     div_dvs;
   div_cmd_type      div_cmd;
   div_stat_type     div_stat;
   logic             changed;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ld        = (state_ff == ST_REPORT) && (!rsp_valid_ff || !rsp_stall);

   // Calibration span and magnitudes (two's complement on W bits)
   assign dlt      = {2'b00, max_ff} - {2'b00, min_ff};
   assign dlt_abs  = dlt[W-1] ? (~dlt + 1'b1) : dlt;
   assign band_mag = {2'b00, quotient[S-1:0]};
   assign diff_abs = diff_ff[W-1] ? (~diff_ff + 1'b1) : diff_ff;
   assign span_abs = span_ff[W-1] ? (~span_ff + 1'b1) : span_ff;

   // Scale by 100 as 64 + 32 + 4
   assign num = {diff_abs[S-1:0], 7'b0} - {diff_abs[S-1:0], 7'b0}
              + {1'b0, diff_abs[S-1:0], 6'b0}
              + {2'b00, diff_abs[S-1:0], 5'b0}
              + {5'b0, diff_abs[S-1:0], 2'b0};

   // Divider operands: deadband on acceptance, mapping after scaling
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.iters = CNT_W'(S);
      div_dvd       = {dlt_abs[S-1:0], {MUL_EXTRA{1'b0}}};
      div_dvs       = S'(DEADBAND_DIV);
      if (req_take) begin
         div_cmd.start = 1'b1;
      end else if (state_ff == ST_MUL) begin
         div_cmd.start = 1'b1;
         div_cmd.iters = CNT_W'(S + MUL_EXTRA);
         div_dvd       = num;
         div_dvs       = span_abs[S-1:0];
      end
   end

   lpcr_div #(
      .DVD_W(DVD_W),
      .DVS_W(S)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .stat     (div_stat),
      .quotient (quotient)
   );

   lpcr_track u_track (
      .clock   (clock),
      .reset   (reset),
      .pos     (pos_ff),
      .commit  (ld),
      .changed (changed)
   );

   // Calibration registers
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MIN_RAW: min_in = csr_wdata;
            REG_MAX_RAW: max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      neg_in   = neg_ff;
      band_in  = band_ff;
      edge_in  = edge_ff;
      span_in  = span_ff;
      diff_in  = diff_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_in     = req_raw_sample;
               neg_in   = dlt[W-1];
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            if (div_stat.done) begin
               band_in  = neg_ff ? (~band_mag + 1'b1) : band_mag;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            edge_in  = {2'b00, min_ff} + band_ff;
            span_in  = dlt - {band_ff[W-2:0], 1'b0};
            state_in = ST_MAP;
         end
         ST_MAP: begin
            diff_in = {2'b00, x_ff} - edge_ff;
            if (span_ff == '0) begin
               // Degenerate span: step from 0 to 100 at the edge
               pos_in   = diff_in[W-1] ? PCT_ZERO : FULL_SCALE;
               state_in = ST_REPORT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            neg_in   = diff_ff[W-1] ^ span_ff[W-1];
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            if (div_stat.done) begin
               if (neg_ff) begin
                  pos_in = PCT_ZERO;
               end else if (quotient > DVD_W'(FULL_SCALE)) begin
                  pos_in = FULL_SCALE;
               end else begin
                  pos_in = quotient[PCT_W-1:0];
               end
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (ld) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_chg_in   = rsp_chg_ff;
      if (ld) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_chg_in   = changed;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '0;
         max_ff       <= S'(MAX_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      neg_ff     <= neg_in;
      band_ff    <= band_in;
      edge_ff    <= edge_in;
      span_ff    <= span_in;
      diff_ff    <= diff_in;
      pos_ff     <= pos_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_chg_ff <= rsp_chg_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_percent = rsp_pos_ff;
   assign rsp_changed          = rsp_chg_ff;

   // An accepted sample always starts the deadband division
   a_take_to_band: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_BAND) && div_stat.busy)
      else $error("accepted sample did not start deadband division");

   // Divider results only arrive while the sequencer waits for them
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_BAND) || (state_ff == ST_QUOT))
      else $error("divider result arrived outside a wait state");

   // Reported position stays in range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position_percent <= FULL_SCALE))
      else $error("position out of range");

   // A new result only appears out of the report state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_REPORT))
      else $error("result appeared without report step");

endmodule
